// ===== rtl/core/normalized_preamble_correlator_core_defines.svh =====
// Assertion macros for the normalized preamble correlator core.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef NORMALIZED_PREAMBLE_CORRELATOR_CORE_DEFINES_SVH
`define NORMALIZED_PREAMBLE_CORRELATOR_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/npc_pkg.sv =====
// Shared types and constants of the normalized preamble correlator.
// Holds the controller/datapath command and status structs and the preamble table.
package npc_pkg;

  localparam int ROM_LEN     = 160;
  localparam int ROM_IDX_W   = 8;
  localparam int MICRO_SCALE = 1000000;
  localparam int Q_FRAC      = 15;
  localparam int RES_W       = Q_FRAC + 1;
  localparam int DRAIN_CYCLES = 2;

  localparam logic [RES_W-1:0] Q_ONE = RES_W'(1) << Q_FRAC;

  typedef struct packed {
    logic accept;
    logic mac_clr;
    logic rd;
    logic mul_load;
    logic mul_step;
    logic check;
    logic srch_step;
    logic out_load;
  } npc_cmd_t;

  typedef struct packed {
    logic win_ready;
    logic mul_done;
    logic ex_zero;
    logic sat;
  } npc_sts_t;

  localparam int ROM_MICRO_I [ROM_LEN] = '{
    1000000, -999800, 992863, -955745, 848732, -625251, 254946, 237120,
    -728495, 995161, -803666, 117841, 700951, -983788, 330258, 715166,
    -905162, -160048, 999277, -156612, -980665, 156490, 999287, 160416,
    -904951, -715600, 329554, 983632, 701660, -116731, -802926, -995294,
    -729516, -238689, 253263, 623795, 847679, 955122, 992594, 999750,
    999997, 998070, 979805, 913080, 752950, 457127, 17459, -496337,
    -906845, -966175, -509440, 314967, 950521, 766044, -219093, -984406,
    -475047, 742721, 778828, -563327, -826269, 627092, 669832, -879754,
    -176462, 975854, -642169, -311545, 949435, -859904, 256628, 422759,
    -868900, 999817, -888576, 656626, -405908, 197824, -59799, 62,
    0, 20006, -119260, 294195, -528823, 780424, -966955, 971480,
    -685051, 98261, 595080, -993032, 713209, 179336, -943891, 698954,
    425066, -987109, 38017, 987660, -195692, -987680, 37768, 987049,
    425516, -698510, -944137, -180192, 712512, 993164, 596078, -96900,
    -683964, -971096, -967397, -781588, -530509, -296214, -121481, -22366,
    -2485, -62094, -199955, -407781, -658078, -889402, -999848, -868130,
    -421464, 257889, 860506, 949102, 310659, -642788, -975704, -175912,
    879960, 669601, -627237, -826234, 563276, 778945, -742513, -475430,
    984307, -218426, -766563, 950231, -313965, -510456, 966510, -906242,
    494987, 19136, -458729, 754216, -913914, 980238, -998210, 1000000
  };

  localparam int ROM_MICRO_Q [ROM_LEN] = '{
    62, -59799, 197824, -405908, 656626, -888576, 999817, -868900,
    422759, 256628, -859904, 949435, -311545, -642169, 975854, -176462,
    -879754, 669832, 627092, -826269, -563327, 778828, 742721, -475047,
    -984406, -219093, 766044, 950521, 314967, -509440, -966175, -906845,
    -496337, 17459, 457127, 752950, 913080, 979805, 998070, 999997,
    999750, 992594, 955122, 847679, 623795, 253263, -238689, -729516,
    -995294, -802926, -116731, 701660, 983632, 329554, -715600, -904951,
    160416, 999287, 156490, -980665, -156612, 999277, -160048, -905162,
    715166, 330258, -983788, 700951, 117841, -803666, 995161, -728495,
    237120, 254946, -625251, 848732, -955745, 992863, -999800, 1000000,
    1000000, -998210, 980238, -913914, 754216, -458729, 19136, 494987,
    -906242, 966510, -510456, -313965, 950231, -766563, -218426, 984307,
    -475430, -742513, 778945, 563276, -826234, -627237, 669601, 879960,
    -175912, -975704, -642788, 310659, 949102, 860506, 257889, -421464,
    -868130, -999848, -889402, -658078, -407781, -199955, -62094, -2485,
    -22366, -121481, -296214, -530509, -781588, -967397, -971096, -683964,
    -96900, 596078, 993164, 712512, -180192, -944137, -698510, 425516,
    987049, 37768, -987680, -195692, 987660, 38017, -987109, 425066,
    698954, -943891, 179336, 713209, -993032, 595080, 98261, -685051,
    971480, -966955, 780424, -528823, 294195, -119260, 20006, 0
  };

endpackage

// ===== rtl/core/npc_datapath.sv =====
// Datapath: sample window memory, complex MAC, energy products and root search.
// Depends on npc_pkg; driven by npc_ctrl through npc_cmd_t.
module npc_datapath import npc_pkg::*; #(
  parameter int WINDOW_LEN  = 160,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  npc_cmd_t                      cmd,
  output npc_sts_t                      sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_q,
  output logic [RES_W-1:0]              out_corr_magnitude,
  output logic                          out_energy_zero
);

  localparam int IDXW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILLW = $clog2(WINDOW_LEN + 1);
  localparam int KW    = (IDXW > ROM_IDX_W) ? IDXW : ROM_IDX_W;
  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int AW    = PW + 1 + $clog2(WINDOW_LEN + 1);
  localparam int EXW   = 2 * SAMPLE_BITS + $clog2(WINDOW_LEN + 1);
  localparam int EPW   = 2 * COEF_BITS + ROM_IDX_W + 1;
  localparam int DW    = EXW + EPW;
  localparam int MBW   = 2 * AW + 1;
  localparam int CW    = ((DW > MBW) ? DW : MBW) + 2 * Q_FRAC + 2;

  typedef logic signed [COEF_BITS-1:0] coef_tab_t [ROM_LEN];

  function automatic logic signed [COEF_BITS-1:0] micro_to_q(input int m);
    longint mag;
    longint full;
    longint v;
    mag  = (m < 0) ? -longint'(m) : longint'(m);
    full = longint'(1) << (COEF_BITS - 1);
    v    = (mag * full + MICRO_SCALE / 2) / MICRO_SCALE;
    if (v > full - 1) v = full - 1;
    return (m < 0) ? COEF_BITS'(-v) : COEF_BITS'(v);
  endfunction

  function automatic coef_tab_t build_tab(input bit quad);
    coef_tab_t t;
    for (int i = 0; i < ROM_LEN; i++) begin
      t[i] = micro_to_q(quad ? ROM_MICRO_Q[i] : ROM_MICRO_I[i]);
    end
    return t;
  endfunction

  localparam coef_tab_t COEF_I = build_tab(1'b0);
  localparam coef_tab_t COEF_Q = build_tab(1'b1);

  function automatic logic [EPW-1:0] pattern_energy();
    longint acc;
    longint ci;
    longint cq;
    acc = 0;
    for (int i = 0; i < ROM_LEN; i++) begin
      ci  = longint'(COEF_I[i]);
      cq  = longint'(COEF_Q[i]);
      acc = acc + ci * ci + cq * cq;
    end
    return EPW'(acc);
  endfunction

  localparam logic [EPW-1:0] EP = pattern_energy();

  logic [2*SAMPLE_BITS-1:0] win_mem [WINDOW_LEN];

  logic [IDXW-1:0]  wr_pos_r, wr_pos_nxt;
  logic [FILLW-1:0] fill_r, fill_nxt;
  logic [IDXW-1:0]  rd_ptr_r;
  logic [KW-1:0]    k_r, k1_r;
  logic             v1_r, v2_r;

  logic [2*SAMPLE_BITS-1:0]       rd_data_r;
  logic signed [SAMPLE_BITS-1:0]  xi, xq;
  logic signed [COEF_BITS-1:0]    ci, cq;
  logic signed [PW-1:0]           p_ii_r, p_qq_r, p_iq_r, p_qi_r;
  logic signed [2*SAMPLE_BITS-1:0] s_ii_r, s_qq_r;

  logic signed [AW-1:0] acc_sr_r, acc_si_r;
  logic [EXW-1:0]       acc_ex_r;

  logic [AW-1:0]  sr_abs, si_abs;
  logic [EXW-1:0] ex_sh_r;
  logic [DW-1:0]  ep_sh_r, d_acc_r;
  logic [AW-1:0]  sr_mul_r, si_mul_r;
  logic [MBW-1:0] sr_mc_r, si_mc_r, m_acc_r;

  logic [CW-1:0]    n_val, cand;
  logic [CW-1:0]    p_r, dqs_r, ds_r;
  logic [RES_W-1:0] q_r, qbit_r;
  logic             zero_r;
  logic [RES_W-1:0] out_corr_r;
  logic             out_zero_r;

  assign wr_pos_nxt = (wr_pos_r == IDXW'(WINDOW_LEN - 1)) ? '0 : wr_pos_r + 1'b1;
  assign fill_nxt   = (fill_r == FILLW'(WINDOW_LEN)) ? fill_r : fill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      fill_r   <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      v1_r <= cmd.rd;
      v2_r <= v1_r;
      if (cmd.accept) begin
        wr_pos_r <= wr_pos_nxt;
        fill_r   <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_mem[wr_pos_r] <= {in_sample_i, in_sample_q};
    end
    if (cmd.rd) begin
      rd_data_r <= win_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      rd_ptr_r <= wr_pos_nxt;
      k_r      <= '0;
    end else if (cmd.rd) begin
      rd_ptr_r <= (rd_ptr_r == IDXW'(WINDOW_LEN - 1)) ? '0 : rd_ptr_r + 1'b1;
      k_r      <= k_r + 1'b1;
    end
    k1_r <= k_r;
  end

  assign xi = rd_data_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign xq = rd_data_r[SAMPLE_BITS-1:0];

  always_comb begin
    ci = '0;
    cq = '0;
    if (k1_r < KW'(ROM_LEN)) begin
      ci = COEF_I[k1_r[ROM_IDX_W-1:0]];
      cq = COEF_Q[k1_r[ROM_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      p_ii_r <= PW'(xi * ci);
      p_qq_r <= PW'(xq * cq);
      p_iq_r <= PW'(xi * cq);
      p_qi_r <= PW'(xq * ci);
      s_ii_r <= xi * xi;
      s_qq_r <= xq * xq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      acc_sr_r <= '0;
      acc_si_r <= '0;
      acc_ex_r <= '0;
    end else if (v2_r) begin
      acc_sr_r <= acc_sr_r + AW'(p_ii_r) - AW'(p_qq_r);
      acc_si_r <= acc_si_r + AW'(p_iq_r) + AW'(p_qi_r);
      acc_ex_r <= acc_ex_r + EXW'($unsigned(s_ii_r)) + EXW'($unsigned(s_qq_r));
    end
  end

  assign sr_abs = acc_sr_r[AW-1] ? $unsigned(-acc_sr_r) : $unsigned(acc_sr_r);
  assign si_abs = acc_si_r[AW-1] ? $unsigned(-acc_si_r) : $unsigned(acc_si_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ex_sh_r  <= acc_ex_r;
      ep_sh_r  <= DW'(EP);
      d_acc_r  <= '0;
      sr_mul_r <= sr_abs;
      si_mul_r <= si_abs;
      sr_mc_r  <= MBW'(sr_abs);
      si_mc_r  <= MBW'(si_abs);
      m_acc_r  <= '0;
    end else if (cmd.mul_step) begin
      ex_sh_r  <= ex_sh_r >> 1;
      ep_sh_r  <= ep_sh_r << 1;
      d_acc_r  <= d_acc_r + (ex_sh_r[0] ? ep_sh_r : '0);
      sr_mul_r <= sr_mul_r >> 1;
      si_mul_r <= si_mul_r >> 1;
      sr_mc_r  <= sr_mc_r << 1;
      si_mc_r  <= si_mc_r << 1;
      m_acc_r  <= m_acc_r + (sr_mul_r[0] ? sr_mc_r : '0) + (si_mul_r[0] ? si_mc_r : '0);
    end
  end

  assign n_val = CW'(m_acc_r) << (2 * Q_FRAC);
  assign cand  = p_r + dqs_r + ds_r;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      p_r    <= '0;
      dqs_r  <= '0;
      ds_r   <= CW'(d_acc_r) << (2 * (Q_FRAC - 1));
      qbit_r <= RES_W'(1) << (Q_FRAC - 1);
      zero_r <= sts.ex_zero;
      q_r    <= (!sts.ex_zero && sts.sat) ? Q_ONE : '0;
    end else if (cmd.srch_step) begin
      ds_r   <= ds_r >> 2;
      qbit_r <= qbit_r >> 1;
      if (cand <= n_val) begin
        p_r   <= cand;
        q_r   <= q_r | qbit_r;
        dqs_r <= (dqs_r >> 1) + ds_r;
      end else begin
        dqs_r <= dqs_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_corr_r <= q_r;
      out_zero_r <= zero_r;
    end
  end

  assign sts.win_ready = (fill_r == FILLW'(WINDOW_LEN - 1)) || (fill_r == FILLW'(WINDOW_LEN));
  assign sts.mul_done  = (ex_sh_r == '0) && (sr_mul_r == '0) && (si_mul_r == '0);
  assign sts.ex_zero   = (acc_ex_r == '0) || (EP == '0);
  assign sts.sat       = CW'(d_acc_r) <= CW'(m_acc_r);

  assign out_corr_magnitude = out_corr_r;
  assign out_energy_zero    = out_zero_r;

endmodule

// ===== rtl/core/npc_ctrl.sv =====
// Controller: sequences accept, MAC sweep, energy products, root search and output.
// Depends on npc_pkg; commands npc_datapath.
module npc_ctrl import npc_pkg::*; #(
  parameter int WINDOW_LEN = 160
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  npc_sts_t sts,
  output npc_cmd_t cmd
);

  localparam int CNT_MAX = (WINDOW_LEN > Q_FRAC) ? WINDOW_LEN : Q_FRAC;
  localparam int CNTW    = $clog2(CNT_MAX + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_SEARCH = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.win_ready) begin
            cmd.mac_clr = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.rd = 1'b1;
        if (cnt_r == CNTW'(WINDOW_LEN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cnt_r == CNTW'(DRAIN_CYCLES - 1)) begin
          state_nxt = S_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LOAD: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = (sts.ex_zero || sts.sat) ? S_FIN : S_SEARCH;
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (cnt_r == CNTW'(Q_FRAC - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/normalized_preamble_correlator_core.sv =====
// Normalized complex preamble correlator. Each input beat is one complex Q1.15 sample that enters
// a WINDOW_LEN-deep window; once the window is full every beat yields one result: the magnitude
// of the plain (unconjugated) correlation with the fixed preamble, divided by the square root of
// window and preamble energies, as unsigned Q1.15 saturated at 32768, or 0 with energy_zero set
// when the window energy is zero. A beat that does not fill the window is taken without holding
// the input. A beat with a result holds the input while the controller reads one window entry
// per cycle through the window memory and the shared complex MAC, runs bit-serial energy products
// over B bits, where B is the bit length of the largest of the window energy and the two
// correlation sums (at most 39 at the defaults), runs a root search for the 15 fraction bits,
// skipped when the energy is zero or the result saturates, and steps through accept, pipeline
// drain and handoff. A finished result waits in the output register while the next beat is
// taken; a result that is still stalled there holds the next one back.
module normalized_preamble_correlator_core import npc_pkg::*; #(
  parameter int WINDOW_LEN  = 160,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_q,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [RES_W-1:0]              out_corr_magnitude,
  output logic                          out_energy_zero
);

  npc_cmd_t cmd;
  npc_sts_t sts;

  npc_ctrl #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  npc_datapath #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample_i       (in_sample_i),
    .in_sample_q       (in_sample_q),
    .out_corr_magnitude(out_corr_magnitude),
    .out_energy_zero   (out_energy_zero)
  );

endmodule

// ===== rtl/core/npc_checker.sv =====
// Port-level checks for the normalized preamble correlator core.
// Uses the macros of normalized_preamble_correlator_core_defines.svh; bound to the top level.
`include "normalized_preamble_correlator_core_defines.svh"

module npc_checker import npc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RES_W-1:0] out_corr_magnitude,
  input logic             out_energy_zero
);

  `NPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_corr_magnitude) && $stable(out_energy_zero), "stalled result beat changed")
  `NPC_ASSERT_SAME(a_zero_res, out_valid && out_energy_zero, out_corr_magnitude == '0, "zero energy with nonzero magnitude")
  `NPC_ASSERT_SAME(a_res_range, out_valid, out_corr_magnitude <= Q_ONE, "magnitude above 1.0")

endmodule

bind normalized_preamble_correlator_core npc_checker u_npc_checker (.*);
